// File: design/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared types and constants of the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2d_pkg;

    localparam int LP_SAMPLE_W   = 16;
    localparam int LP_MAX_WIDTH  = 1024;
    localparam int LP_MAX_HEIGHT = 1024;
    localparam int LP_MAX_KERNEL = 8;

    // line store keeps the previous max kernel-1 rows, packed per column
    localparam int LP_SLOTS  = LP_MAX_KERNEL - 1;
    localparam int LP_SLOT_W = $clog2(LP_SLOTS);
    localparam int LP_WORD_W = LP_SLOTS * LP_SAMPLE_W;

    localparam int LP_COL_W = $clog2(LP_MAX_WIDTH);
    localparam int LP_ROW_W = $clog2(LP_MAX_HEIGHT);

    localparam int LP_KSZ_W      = 4;
    localparam int LP_STEP_W     = 4;
    localparam int LP_DIM_W      = 11;
    localparam int LP_CFG_IDX_W  = 3;
    localparam int LP_CFG_DATA_W = 11;
    localparam int LP_OUT_IDX_W  = 10;

    localparam int LP_FIFO_DEPTH = 4;
    localparam int LP_FIFO_PTR_W = $clog2(LP_FIFO_DEPTH);
    localparam int LP_FIFO_CNT_W = $clog2(LP_FIFO_DEPTH + 1);

    typedef enum logic [LP_CFG_IDX_W-1:0] {
        CFG_KERNEL_SIZE  = 3'd0,
        CFG_STEP_SIZE    = 3'd1,
        CFG_PLANE_WIDTH  = 3'd2,
        CFG_PLANE_HEIGHT = 3'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [LP_SAMPLE_W-1:0] max_value;
        logic [LP_OUT_IDX_W-1:0]       out_row;
        logic [LP_OUT_IDX_W-1:0]       out_col;
        logic                          plane_done;
    } t_result;

endpackage

`default_nettype wire

// File: design/mp2d_out_fifo.sv
// ----------------------------------------------------------------------------
// mp2d_out_fifo
// Small register fifo that holds pooled results until the sink takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_out_fifo import mp2d_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_push,
    input  wire t_result                  i_data,
    input  wire logic                     i_stall,
    output logic                          o_valid,
    output t_result                       o_data,
    output logic [LP_FIFO_CNT_W-1:0]      o_count
);

    t_result                  r_mem [LP_FIFO_DEPTH];
    logic [LP_FIFO_PTR_W-1:0] r_wr_ptr;
    logic [LP_FIFO_PTR_W-1:0] r_rd_ptr;
    logic [LP_FIFO_CNT_W-1:0] r_count;
    logic [LP_FIFO_CNT_W-1:0] n_count;
    logic                     pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: design/max_pool_2d_stream.sv
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// Streaming square max pooling over raster-order planes, line store in RAM.
// ----------------------------------------------------------------------------
// path: a sample passes the stage 1, stage 2 and result fifo registers
// throughput: one sample per cycle when not stalled; the line store does one
//   read and one write-back per cycle, forwarding when a column follows itself
// reset: counters, pipeline and result fifo cleared, registers to their
//   defaults; the line store is not cleared and is never used before written
// ----------------------------------------------------------------------------
`default_nettype none

module max_pool_2d_stream import mp2d_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // sample channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [LP_SAMPLE_W-1:0] i_sample,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic signed [LP_SAMPLE_W-1:0]      o_max_value,
    output logic [LP_OUT_IDX_W-1:0]            o_out_row,
    output logic [LP_OUT_IDX_W-1:0]            o_out_col,
    output logic                               o_plane_done,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [LP_CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [LP_CFG_DATA_W-1:0]      i_cfg_data
);

    function automatic logic signed [LP_SAMPLE_W-1:0] f_max(
        input logic signed [LP_SAMPLE_W-1:0] a,
        input logic signed [LP_SAMPLE_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // configuration
    logic [LP_KSZ_W-1:0]  r_kernel_raw;
    logic [LP_STEP_W-1:0] r_step_raw;
    logic [LP_DIM_W-1:0]  r_width_raw;
    logic [LP_DIM_W-1:0]  r_height_raw;
    logic [LP_KSZ_W-1:0]  k_eff;
    logic [LP_STEP_W-1:0] s_eff;
    logic [LP_DIM_W-1:0]  w_eff;
    logic [LP_DIM_W-1:0]  h_eff;
    logic                 cfg_we;
    logic                 restart;

    // position counters
    logic [LP_ROW_W-1:0]     r_row,    n_row;
    logic [LP_COL_W-1:0]     r_col,    n_col;
    logic [LP_SLOT_W-1:0]    r_slot,   n_slot;
    logic [LP_STEP_W-1:0]    r_row_ph, n_row_ph;
    logic [LP_STEP_W-1:0]    r_col_ph, n_col_ph;
    logic [LP_OUT_IDX_W-1:0] r_orow,   n_orow;
    logic [LP_OUT_IDX_W-1:0] r_ocol,   n_ocol;

    logic accept;
    logic row_in;
    logic col_in;
    logic hit_row;
    logic hit_col;
    logic last_row;
    logic last_col;
    logic col_end;
    logic row_end;

    // stage 1: line store read-modify-write and column max
    logic                          r_s1_valid;
    logic                          r_s1_emit;
    logic                          r_s1_last;
    logic signed [LP_SAMPLE_W-1:0] r_s1_sample;
    logic [LP_COL_W-1:0]           r_s1_col;
    logic [LP_ROW_W-1:0]           r_s1_row;
    logic [LP_SLOT_W-1:0]          r_s1_slot;
    logic [LP_OUT_IDX_W-1:0]       r_s1_orow;
    logic [LP_OUT_IDX_W-1:0]       r_s1_ocol;

    logic [LP_WORD_W-1:0]          line_mem [LP_MAX_WIDTH];
    logic [LP_WORD_W-1:0]          r_rd_word;
    logic [LP_WORD_W-1:0]          r_fwd_word;
    logic                          r_fwd_hit;
    logic [LP_WORD_W-1:0]          cur_word;
    logic [LP_WORD_W-1:0]          n_word;
    logic signed [LP_SAMPLE_W-1:0] slot_val [LP_SLOTS];
    logic [LP_SLOT_W:0]            slot_dist [LP_SLOTS];
    logic [LP_SLOTS-1:0]           slot_use;
    logic signed [LP_SAMPLE_W-1:0] col_max;

    // column maxima of the last kernel columns, newest first
    logic signed [LP_SAMPLE_W-1:0] r_win [LP_MAX_KERNEL];

    // stage 2: window max
    logic                          r_s2_valid;
    logic                          r_s2_last;
    logic [LP_OUT_IDX_W-1:0]       r_s2_orow;
    logic [LP_OUT_IDX_W-1:0]       r_s2_ocol;
    logic signed [LP_SAMPLE_W-1:0] win_max;

    t_result                       push_data;
    t_result                       fifo_data;
    logic [LP_FIFO_CNT_W-1:0]      fifo_count;
    logic [LP_FIFO_CNT_W:0]        in_flight;

    // ---------------------------------------------------------------- config

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (r_kernel_raw == '0) begin
            k_eff = LP_KSZ_W'(1);
        end else if (r_kernel_raw > LP_KSZ_W'(LP_MAX_KERNEL)) begin
            k_eff = LP_KSZ_W'(LP_MAX_KERNEL);
        end else begin
            k_eff = r_kernel_raw;
        end
        s_eff = (r_step_raw == '0) ? LP_STEP_W'(1) : r_step_raw;
        if (r_width_raw == '0) begin
            w_eff = LP_DIM_W'(1);
        end else if (r_width_raw > LP_DIM_W'(LP_MAX_WIDTH)) begin
            w_eff = LP_DIM_W'(LP_MAX_WIDTH);
        end else begin
            w_eff = r_width_raw;
        end
        if (r_height_raw == '0) begin
            h_eff = LP_DIM_W'(1);
        end else if (r_height_raw > LP_DIM_W'(LP_MAX_HEIGHT)) begin
            h_eff = LP_DIM_W'(LP_MAX_HEIGHT);
        end else begin
            h_eff = r_height_raw;
        end
    end

    always_comb begin
        case (t_cfg_reg'(i_cfg_index))
            CFG_KERNEL_SIZE, CFG_STEP_SIZE, CFG_PLANE_WIDTH, CFG_PLANE_HEIGHT: begin
                restart = cfg_we;
            end
            default: begin
                restart = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_raw <= LP_KSZ_W'(2);
            r_step_raw   <= LP_STEP_W'(2);
            r_width_raw  <= LP_DIM_W'(LP_MAX_WIDTH);
            r_height_raw <= LP_DIM_W'(LP_MAX_HEIGHT);
        end else if (cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_KERNEL_SIZE:  r_kernel_raw <= i_cfg_data[LP_KSZ_W-1:0];
                CFG_STEP_SIZE:    r_step_raw   <= i_cfg_data[LP_STEP_W-1:0];
                CFG_PLANE_WIDTH:  r_width_raw  <= i_cfg_data;
                CFG_PLANE_HEIGHT: r_height_raw <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------- accept and position

    // every item that may still produce a result holds a fifo slot
    assign in_flight  = (LP_FIFO_CNT_W+1)'(fifo_count)
                      + (LP_FIFO_CNT_W+1)'(r_s1_valid && r_s1_emit)
                      + (LP_FIFO_CNT_W+1)'(r_s2_valid);
    assign o_in_stall = (in_flight >= (LP_FIFO_CNT_W+1)'(LP_FIFO_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;

    // window rows/cols are those whose last line lands on a stride multiple
    assign row_in   = (LP_DIM_W'(r_row) + LP_DIM_W'(1)) >= LP_DIM_W'(k_eff);
    assign col_in   = (LP_DIM_W'(r_col) + LP_DIM_W'(1)) >= LP_DIM_W'(k_eff);
    assign hit_row  = row_in && (r_row_ph == '0);
    assign hit_col  = col_in && (r_col_ph == '0);
    assign last_row = ((LP_DIM_W+1)'(r_row) + (LP_DIM_W+1)'(s_eff))
                      >= (LP_DIM_W+1)'(h_eff);
    assign last_col = ((LP_DIM_W+1)'(r_col) + (LP_DIM_W+1)'(s_eff))
                      >= (LP_DIM_W+1)'(w_eff);
    assign col_end  = (LP_DIM_W'(r_col) + LP_DIM_W'(1)) >= w_eff;
    assign row_end  = (LP_DIM_W'(r_row) + LP_DIM_W'(1)) >= h_eff;

    always_comb begin
        n_row    = r_row;
        n_col    = r_col;
        n_slot   = r_slot;
        n_row_ph = r_row_ph;
        n_col_ph = r_col_ph;
        n_orow   = r_orow;
        n_ocol   = r_ocol;
        if (col_end) begin
            n_col    = '0;
            n_col_ph = '0;
            n_ocol   = '0;
            if (row_end) begin
                n_row    = '0;
                n_slot   = '0;
                n_row_ph = '0;
                n_orow   = '0;
            end else begin
                n_row  = r_row + 1'b1;
                n_slot = (r_slot == LP_SLOT_W'(LP_SLOTS - 1)) ? '0 : r_slot + 1'b1;
                if (row_in) begin
                    n_row_ph = (LP_STEP_W'(r_row_ph + 1'b1) == s_eff) ? '0
                             : r_row_ph + 1'b1;
                end
                if (hit_row) begin
                    n_orow = r_orow + 1'b1;
                end
            end
        end else begin
            n_col = r_col + 1'b1;
            if (col_in) begin
                n_col_ph = (LP_STEP_W'(r_col_ph + 1'b1) == s_eff) ? '0
                         : r_col_ph + 1'b1;
            end
            if (hit_col) begin
                n_ocol = r_ocol + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_slot   <= '0;
            r_row_ph <= '0;
            r_col_ph <= '0;
            r_orow   <= '0;
            r_ocol   <= '0;
        end else if (restart) begin
            r_row    <= '0;
            r_col    <= '0;
            r_slot   <= '0;
            r_row_ph <= '0;
            r_col_ph <= '0;
            r_orow   <= '0;
            r_ocol   <= '0;
        end else if (accept) begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_slot   <= n_slot;
            r_row_ph <= n_row_ph;
            r_col_ph <= n_col_ph;
            r_orow   <= n_orow;
            r_ocol   <= n_ocol;
        end
    end

    // ------------------------------------------------------------ line store

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            line_mem[r_s1_col] <= n_word;
        end
        if (accept) begin
            r_rd_word <= line_mem[r_col];
        end
    end

    // a one-column plane reads the word being written back in the same cycle
    assign cur_word = r_fwd_hit ? r_fwd_word : r_rd_word;

    always_comb begin
        n_word  = cur_word;
        col_max = r_s1_sample;
        for (int p = 0; p < LP_SLOTS; p++) begin
            slot_val[p]  = cur_word[p*LP_SAMPLE_W +: LP_SAMPLE_W];
            // rows back from the current one, 1..slots; own slot is oldest row
            slot_dist[p] = (LP_SLOT_W+1)'(r_s1_slot)
                         + (LP_SLOT_W+1)'(LP_SLOTS - 1 - p);
            if (slot_dist[p] >= (LP_SLOT_W+1)'(LP_SLOTS)) begin
                slot_dist[p] = slot_dist[p] - (LP_SLOT_W+1)'(LP_SLOTS);
            end
            slot_dist[p] = slot_dist[p] + 1'b1;
            slot_use[p]  = (LP_KSZ_W'(slot_dist[p]) < k_eff)
                         && (r_s1_row >= LP_ROW_W'(slot_dist[p]));
            if (slot_use[p]) begin
                col_max = f_max(col_max, slot_val[p]);
            end
            if (r_s1_slot == LP_SLOT_W'(p)) begin
                n_word[p*LP_SAMPLE_W +: LP_SAMPLE_W] = r_s1_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s1_emit  <= accept && hit_row && hit_col;
            r_fwd_hit  <= accept && r_s1_valid && (r_s1_col == r_col);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_word <= n_word;
        if (accept) begin
            r_s1_sample <= i_sample;
            r_s1_col    <= r_col;
            r_s1_row    <= r_row;
            r_s1_slot   <= r_slot;
            r_s1_orow   <= r_orow;
            r_s1_ocol   <= r_ocol;
            r_s1_last   <= last_row && last_col;
        end
    end

    // --------------------------------------------------------- column window

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LP_MAX_KERNEL; i++) begin
                r_win[i] <= '0;
            end
        end else if (restart) begin
            for (int i = 0; i < LP_MAX_KERNEL; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_s1_valid) begin
            r_win[0] <= col_max;
            for (int i = 1; i < LP_MAX_KERNEL; i++) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    always_comb begin
        win_max = r_win[0];
        for (int i = 1; i < LP_MAX_KERNEL; i++) begin
            if (LP_KSZ_W'(i) < k_eff) begin
                win_max = f_max(win_max, r_win[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_orow <= r_s1_orow;
            r_s2_ocol <= r_s1_ocol;
            r_s2_last <= r_s1_last;
        end
    end

    // ---------------------------------------------------------------- output

    always_comb begin
        push_data.max_value  = win_max;
        push_data.out_row    = r_s2_orow;
        push_data.out_col    = r_s2_ocol;
        push_data.plane_done = r_s2_last;
    end

    mp2d_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_valid),
        .i_data  (push_data),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (fifo_data),
        .o_count (fifo_count)
    );

    assign o_max_value  = fifo_data.max_value;
    assign o_out_row    = fifo_data.out_row;
    assign o_out_col    = fifo_data.out_col;
    assign o_plane_done = fifo_data.plane_done;

endmodule

`default_nettype wire

// File: tb/tb_max_pool_2d_stream.sv
// ----------------------------------------------------------------------------
// tb_max_pool_2d_stream
// Self-checking bench for the streaming max pooling block: a directed table
// of corner cases, then random plane shapes and samples under several
// handshake pressure patterns, each result checked against a local model or a table entry.
// ----------------------------------------------------------------------------
module tb_max_pool_2d_stream;
    timeunit 1ns;
    timeprecision 1ps;

    import mp2d_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 6;
    localparam int LAT_WAIT     = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TOTAL_ITEMS  = 1350;
    localparam int PHASE_CAP    = 64;
    localparam int N_CFG_REGS   = 4;

    // first index past the register list, writes there change nothing
    localparam logic [LP_CFG_IDX_W-1:0] CFG_SPARE_BASE = 3'd4;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;
    typedef enum logic [1:0] {ROW_CFG, ROW_SMP, ROW_SMP_LIT} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [LP_CFG_IDX_W-1:0]       idx;
        logic [LP_CFG_DATA_W-1:0]      data;
        logic signed [LP_SAMPLE_W-1:0] smp;
        logic                          lit_hit;
        t_result                       lit;
    } t_dir_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic signed [LP_SAMPLE_W-1:0] i_sample;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [LP_SAMPLE_W-1:0] o_max_value;
    logic [LP_OUT_IDX_W-1:0]       o_out_row;
    logic [LP_OUT_IDX_W-1:0]       o_out_col;
    logic                          o_plane_done;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [LP_CFG_IDX_W-1:0]       i_cfg_index;
    logic [LP_CFG_DATA_W-1:0]      i_cfg_data;

    // pooling model state
    logic [LP_KSZ_W-1:0]           cfg_kernel;
    logic [LP_STEP_W-1:0]          cfg_step;
    logic [LP_DIM_W-1:0]           cfg_width;
    logic [LP_DIM_W-1:0]           cfg_height;
    int                            at_row;
    int                            at_col;
    logic signed [LP_SAMPLE_W-1:0] ln_store [LP_SLOTS][LP_MAX_WIDTH];
    logic signed [LP_SAMPLE_W-1:0] colmax_sr [LP_MAX_KERNEL];
    t_result                       pooled_q [$];

    t_idle_mode idle_mode = IDLE_NONE;
    t_dir_row   dir_tab [$];
    int         n_samples  = 0;
    int         n_phases   = 0;
    int         cfg_writes = 0;
    int         n_checked  = 0;
    int         n_err      = 0;
    int         n_cycles   = 0;

    max_pool_2d_stream dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_max_value  (o_max_value),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_plane_done (o_plane_done),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    function automatic int clamp_dim(int v, int lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic int idle_pct(t_idle_mode mode, logic sender_side);
        if (mode == IDLE_BOTH) return 17;
        if (mode == (sender_side ? IDLE_SEND : IDLE_RECV)) return 54;
        return 0;
    endfunction

    function automatic t_dir_row cfg_row(logic [LP_CFG_IDX_W-1:0] idx,
                                         logic [LP_CFG_DATA_W-1:0] data);
        t_dir_row row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic t_dir_row smp_row(logic signed [LP_SAMPLE_W-1:0] x);
        t_dir_row row;
        row      = '0;
        row.kind = ROW_SMP;
        row.smp  = x;
        return row;
    endfunction

    function automatic t_dir_row lit_row(logic signed [LP_SAMPLE_W-1:0] x, logic hit,
                                         logic signed [LP_SAMPLE_W-1:0] mv,
                                         int r, int c, logic done);
        t_dir_row row;
        row                = '0;
        row.kind           = ROW_SMP_LIT;
        row.smp            = x;
        row.lit_hit        = hit;
        row.lit.max_value  = mv;
        row.lit.out_row    = LP_OUT_IDX_W'(r);
        row.lit.out_col    = LP_OUT_IDX_W'(c);
        row.lit.plane_done = done;
        return row;
    endfunction

    function automatic logic signed [LP_SAMPLE_W-1:0] pick_sample(int style);
        case (style)
            0: return LP_SAMPLE_W'($urandom);
            // narrow range gives lots of ties
            1: return LP_SAMPLE_W'($urandom_range(0, 8)) - 16'sd4;
            default: begin
                if ($urandom_range(1) == 0) return LP_SAMPLE_W'($urandom);
                return ($urandom_range(1) == 0) ? 16'sh8000 : 16'sh7FFF;
            end
        endcase
    endfunction

    function automatic logic [LP_CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return '0;
            1:       return LP_CFG_DATA_W'($urandom_range(13, 40));
            default: return LP_CFG_DATA_W'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic restart_plane();
        at_row = 0;
        at_col = 0;
        foreach (colmax_sr[i]) colmax_sr[i] = '0;
    endtask

    task automatic cfg_apply(logic [LP_CFG_IDX_W-1:0] idx, logic [LP_CFG_DATA_W-1:0] data);
        case (idx)
            CFG_KERNEL_SIZE:  cfg_kernel = data[LP_KSZ_W-1:0];
            CFG_STEP_SIZE:    cfg_step   = data[LP_STEP_W-1:0];
            CFG_PLANE_WIDTH:  cfg_width  = data;
            CFG_PLANE_HEIGHT: cfg_height = data;
            default:          return;
        endcase
        restart_plane();
    endtask

    task automatic pool_predict(input logic signed [LP_SAMPLE_W-1:0] x,
                                output logic hit, output t_result res);
        int k, s, w, h, r, c, j;
        logic signed [LP_SAMPLE_W-1:0] cm, m;
        k = (cfg_kernel == 0) ? 1 :
            ((cfg_kernel > LP_MAX_KERNEL) ? LP_MAX_KERNEL : int'(cfg_kernel));
        s = (cfg_step == 0) ? 1 : int'(cfg_step);
        w = clamp_dim(cfg_width, LP_MAX_WIDTH);
        h = clamp_dim(cfg_height, LP_MAX_HEIGHT);
        if (at_col >= w) at_col = 0;
        if (at_row >= h) at_row = 0;
        r  = at_row;
        c  = at_col;
        cm = x;
        // column maximum over the rows held in the line store
        for (j = 1; j < k; j++)
            if (r >= j && ln_store[(r - j) % LP_SLOTS][c] > cm)
                cm = ln_store[(r - j) % LP_SLOTS][c];
        for (j = LP_MAX_KERNEL - 1; j > 0; j--) colmax_sr[j] = colmax_sr[j - 1];
        colmax_sr[0] = cm;
        ln_store[r % LP_SLOTS][c] = x;
        hit = (r + 1 >= k) && (c + 1 >= k) &&
              ((r + 1 - k) % s == 0) && ((c + 1 - k) % s == 0);
        res = '0;
        if (hit) begin
            m = colmax_sr[0];
            for (j = 1; j < k; j++) if (colmax_sr[j] > m) m = colmax_sr[j];
            res.max_value  = m;
            res.out_row    = LP_OUT_IDX_W'((r + 1 - k) / s);
            res.out_col    = LP_OUT_IDX_W'((c + 1 - k) / s);
            res.plane_done = ((r + 1 - k) / s == (h - k) / s) &&
                             ((c + 1 - k) / s == (w - k) / s);
        end
        at_col = c + 1;
        if (at_col >= w) begin
            at_col = 0;
            at_row = (r + 1 >= h) ? 0 : r + 1;
        end
    endtask

    task automatic report_mismatch(string what, logic signed [31:0] got,
                                   logic signed [31:0] want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 n_checked, what, got, want);
        n_err++;
    endtask

    // drop valid and wait until every pooled result is out, then the pipe drains
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pooled_q.size() != 0);
        repeat (LAT_WAIT) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [LP_CFG_IDX_W-1:0] idx,
                             input logic [LP_CFG_DATA_W-1:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_apply(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_sample(input logic signed [LP_SAMPLE_W-1:0] x, input logic use_lit,
                               input logic lit_hit, input t_result lit);
        logic    hit;
        t_result res;
        while ($urandom_range(99) < idle_pct(idle_mode, 1'b1)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= x;
        do @(posedge i_clk); while (o_in_stall);
        pool_predict(x, hit, res);
        if (use_lit) begin
            hit = lit_hit;
            res = lit;
        end
        if (hit) pooled_q.push_back(res);
        n_samples++;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [LP_CFG_DATA_W-1:0] kd, sd, wd, hd,
                             input int planes, cut, style, pause_at,
                             input t_idle_mode mode);
        logic [LP_CFG_DATA_W-1:0] vals [N_CFG_REGS];
        int first, n, i;
        vals      = '{kd, sd, wd, hd};
        idle_mode = mode;
        first     = $urandom_range(N_CFG_REGS - 1);
        for (i = 0; i < N_CFG_REGS; i++)
            cfg_write(LP_CFG_IDX_W'((first + i) % N_CFG_REGS), vals[(first + i) % N_CFG_REGS]);
        if ($urandom_range(3) == 0)
            cfg_write(CFG_SPARE_BASE | LP_CFG_IDX_W'($urandom_range(3)),
                      LP_CFG_DATA_W'($urandom));
        n = clamp_dim(cfg_width, LP_MAX_WIDTH) * clamp_dim(cfg_height, LP_MAX_HEIGHT) * planes;
        // a cut plane is restarted by the next register write
        if (cut > 0 && cut < n) n = cut;
        for (i = 0; i < n; i++) begin
            if (i == pause_at || $urandom_range(199) == 0) settle();
            send_sample(pick_sample(style), 1'b0, 1'b0, '0);
        end
        n_phases++;
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < idle_pct(idle_mode, 1'b0));
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pooled_q.size() == 0) begin
                report_mismatch("result with nothing expected, max_value", o_max_value, 0);
            end else begin
                want = pooled_q.pop_front();
                if (o_max_value !== want.max_value)
                    report_mismatch("max_value", o_max_value, want.max_value);
                if (o_out_row !== want.out_row)
                    report_mismatch("out_row", o_out_row, want.out_row);
                if (o_out_col !== want.out_col)
                    report_mismatch("out_col", o_out_col, want.out_col);
                if (o_plane_done !== want.plane_done)
                    report_mismatch("plane_done", o_plane_done, want.plane_done);
            end
            n_checked++;
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("run stopped by the cycle limit");
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int ksel, ssel, cut;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cfg_kernel  = 4'd2;
        cfg_step    = 4'd2;
        cfg_width   = 11'd1024;
        cfg_height  = 11'd1024;
        restart_plane();

        dir_tab = {
            // defaults after reset: first sample of a big plane closes nothing
            lit_row(16'sd7, 1'b0, 0, 0, 0, 1'b0),
            cfg_row(CFG_KERNEL_SIZE, 11'd2), cfg_row(CFG_STEP_SIZE, 11'd2),
            cfg_row(CFG_PLANE_WIDTH, 11'd2), cfg_row(CFG_PLANE_HEIGHT, 11'd2),
            lit_row(16'sh8000, 1'b0, 0, 0, 0, 1'b0),
            lit_row(16'sh8000, 1'b0, 0, 0, 0, 1'b0),
            lit_row(16'sh8000, 1'b0, 0, 0, 0, 1'b0),
            lit_row(16'sh8000, 1'b1, 16'sh8000, 0, 0, 1'b1),
            lit_row(16'sh8000, 1'b0, 0, 0, 0, 1'b0),
            lit_row(16'sh8000, 1'b0, 0, 0, 0, 1'b0),
            lit_row(16'sh8000, 1'b0, 0, 0, 0, 1'b0),
            lit_row(16'sh7FFF, 1'b1, 16'sh7FFF, 0, 0, 1'b1),
            // 1x1 window passes samples through
            cfg_row(CFG_KERNEL_SIZE, 11'd1), cfg_row(CFG_STEP_SIZE, 11'd1),
            cfg_row(CFG_PLANE_WIDTH, 11'd3), cfg_row(CFG_PLANE_HEIGHT, 11'd1),
            lit_row(16'sd1, 1'b1, 16'sd1, 0, 0, 1'b0),
            // write past the register list mid-plane, no restart
            cfg_row(CFG_SPARE_BASE, 11'h7FF),
            lit_row(-16'sd1, 1'b1, -16'sd1, 0, 1, 1'b0),
            lit_row(16'sd12345, 1'b1, 16'sd12345, 0, 2, 1'b1),
            // zero values all act as one
            cfg_row(CFG_KERNEL_SIZE, 11'h7F0), cfg_row(CFG_STEP_SIZE, 11'h7F0),
            cfg_row(CFG_PLANE_WIDTH, 11'd0), cfg_row(CFG_PLANE_HEIGHT, 11'd0),
            lit_row(16'shAAAA, 1'b1, 16'shAAAA, 0, 0, 1'b1),
            // kernel saturates to eight, plane smaller than the window
            cfg_row(CFG_KERNEL_SIZE, 11'd15), cfg_row(CFG_STEP_SIZE, 11'd1),
            cfg_row(CFG_PLANE_WIDTH, 11'd2), cfg_row(CFG_PLANE_HEIGHT, 11'd2),
            lit_row(16'sd100, 1'b0, 0, 0, 0, 1'b0),
            lit_row(-16'sd100, 1'b0, 0, 0, 0, 1'b0),
            lit_row(16'sd7, 1'b0, 0, 0, 0, 1'b0),
            lit_row(16'sd0, 1'b0, 0, 0, 0, 1'b0),
            cfg_row(CFG_KERNEL_SIZE, 11'd3), cfg_row(CFG_STEP_SIZE, 11'd1),
            cfg_row(CFG_PLANE_WIDTH, 11'd3), cfg_row(CFG_PLANE_HEIGHT, 11'd3),
            smp_row(16'sd5), smp_row(-16'sd3), smp_row(16'sd9),
            smp_row(16'sd2), smp_row(16'sd11), smp_row(-16'sd20),
            smp_row(16'sd0), smp_row(16'sd4), smp_row(-16'sd1)
        };

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG)
                cfg_write(dir_tab[i].idx, dir_tab[i].data);
            else
                send_sample(dir_tab[i].smp, dir_tab[i].kind == ROW_SMP_LIT,
                            dir_tab[i].lit_hit, dir_tab[i].lit);
        end

        // widest plane via saturation, one full row, with a drain pause halfway
        run_phase(11'd1, 11'd1, 11'd2047, 11'd1, 1, 0, 2, 512, IDLE_RECV);
        // tallest plane, cut short and restarted by the next writes
        run_phase(11'd1, 11'd7, 11'd1, 11'd1024, 1, 100, 0, -1, IDLE_SEND);

        while (n_samples < TOTAL_ITEMS) begin
            ksel = ($urandom_range(3) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 15);
            ssel = ($urandom_range(3) != 0) ? $urandom_range(1, 4) : $urandom_range(0, 15);
            cut  = ($urandom_range(4) == 0) ? $urandom_range(1, 30) : 0;
            // short phases so every idle pattern gets a turn within the budget
            if (cut == 0 || cut > PHASE_CAP) cut = PHASE_CAP;
            if (cut > TOTAL_ITEMS - n_samples) cut = TOTAL_ITEMS - n_samples;
            run_phase({7'($urandom), 4'(ksel)}, {7'($urandom), 4'(ssel)},
                      pick_dim(), pick_dim(), $urandom_range(1, 3),
                      cut, $urandom_range(2), -1, t_idle_mode'(n_phases % 4));
        end

        settle();
        $display("covered %0d samples in %0d shaped phases, %0d register writes",
                 n_samples, n_phases, cfg_writes);
        $display("%0d pooled results compared, %0d mismatches", n_checked, n_err);
        if (n_err == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: max_pool_2d_stream.f
design/mp2d_pkg.sv
design/mp2d_out_fifo.sv
design/max_pool_2d_stream.sv
tb/tb_max_pool_2d_stream.sv
